// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/edfrms_pkg.sv
// ----------------------------------------------------------------------------
// edfrms_pkg
// types and constants of the edf / rms job scheduler
// ----------------------------------------------------------------------------
package edfrms_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    localparam int CNT_SAT = 127;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  task_id;
        logic [15:0] release_req;
        logic [15:0] execution;
        logic [15:0] deadline;
        logic [15:0] period;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic        idle;
        logic [3:0]  run_task;
        logic [5:0]  run_slot;
        logic        job_finished;
        logic        finished_late;
        logic [15:0] executed_ticks;
        logic [6:0]  completed_jobs;
        logic [6:0]  missed_jobs;
        logic [6:0]  job_total;
    } t_out;

    // best candidate travelling along the cell row
    typedef struct packed {
        logic        vld;
        logic        found;
        logic [7:0]  slot;
        logic [3:0]  task_id;
        logic [15:0] release_t;
        logic [15:0] deadline;
        logic [15:0] period;
        logic [15:0] remaining;
    } t_cand;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        wr_en;
        logic        dec_en;
        logic [7:0]  slot;
        logic        use_edf;
        logic [15:0] tick;
    } t_cell_ctl;

endpackage

// File: rtl/edf_rms_job_scheduler_top.sv
// ----------------------------------------------------------------------------
// edf_rms_job_scheduler_top
// job table with edf or rms selection over a row of slot cells
// ----------------------------------------------------------------------------
// An add or report transaction returns its result in the cycle after it is taken.
// In a tick transaction a candidate walks the row of
// slot cells one cell per cycle, then the winner is updated and reported.
// One transaction is in work at a time.
module edf_rms_job_scheduler_top
    import edfrms_pkg::*;
#(
    parameter int MAX_JOBS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int CNT_W = $clog2(MAX_JOBS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} t_state;

    t_state           r_state;
    logic             r_use_edf;
    logic             r_start;
    logic [CNT_W-1:0] r_cnt;
    logic [15:0]      r_tick;
    logic [15:0]      r_busy;
    logic [6:0]       r_fin;
    logic [6:0]       r_late;
    t_cand            r_win;
    logic             r_out_valid;
    t_out             r_out;
    logic             n_out_valid;
    t_out             n_out;

    t_cand            w_cand [0:MAX_JOBS];
    t_cell_ctl        w_ctl;
    logic             w_acc;
    logic             w_add_ok;
    logic             w_out_free;
    logic             w_emit;
    logic             w_fin;
    logic             w_late;
    logic [8:0]       w_cnt9;
    logic [8:0]       w_unfin;
    logic [9:0]       w_missed;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || !w_out_free;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_add_ok   = (r_cnt < CNT_W'(MAX_JOBS)) && (i_in_data.execution != 16'd0);
    assign w_emit     = (r_state == ST_DONE) && w_out_free;
    assign w_fin      = r_win.found && (r_win.remaining == 16'd1);
    assign w_late     = w_fin && (({1'b0, r_tick} + 17'd1) > {1'b0, r_win.deadline});

    assign w_cnt9   = 9'(r_cnt);
    assign w_unfin  = (w_cnt9 > {2'b0, r_fin}) ? (w_cnt9 - {2'b0, r_fin}) : 9'd0;
    assign w_missed = {3'b0, r_late} + {1'b0, w_unfin};

    always_comb begin
        w_ctl.wr_en   = w_acc && (i_in_data.func == FUNC_ADD) && w_add_ok;
        w_ctl.dec_en  = w_emit && r_win.found;
        w_ctl.slot    = w_ctl.wr_en ? 8'(r_cnt) : r_win.slot;
        w_ctl.use_edf = r_use_edf;
        w_ctl.tick    = r_tick;
        w_cand[0]     = '0;
        w_cand[0].vld = r_start;
    end

    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        edfrms_cell #(
            .SLOT  (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_wr_data (i_in_data),
            .i_cnt     (r_cnt),
            .i_cand    (w_cand[g]),
            .o_cand    (w_cand[g+1])
        );
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (w_acc && (i_in_data.func != FUNC_TICK)) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            unique case (i_in_data.func)
                FUNC_ADD: begin
                    n_out.accepted = w_add_ok;
                end
                FUNC_REPORT: begin
                    n_out.executed_ticks = r_busy;
                    n_out.completed_jobs = r_fin;
                    n_out.missed_jobs    = (w_missed > 10'(CNT_SAT)) ?
                                           7'(CNT_SAT) : w_missed[6:0];
                    n_out.job_total      = (w_cnt9 > 9'(CNT_SAT)) ?
                                           7'(CNT_SAT) : w_cnt9[6:0];
                end
                default: begin
                end
            endcase
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            n_out.idle  = !r_win.found;
            if (r_win.found) begin
                n_out.run_task      = r_win.task_id;
                n_out.run_slot      = r_win.slot[5:0];
                n_out.job_finished  = w_fin;
                n_out.finished_late = w_late;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_use_edf   <= 1'b1;
            r_start     <= 1'b0;
            r_cnt       <= '0;
            r_tick      <= '0;
            r_busy      <= '0;
            r_fin       <= '0;
            r_late      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start     <= w_acc && (i_in_data.func == FUNC_TICK);
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_use_edf <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_in_data.func == FUNC_TICK) begin
                            r_state <= ST_SCAN;
                        end
                        if (w_ctl.wr_en) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_cand[MAX_JOBS].vld) begin
                        r_win   <= w_cand[MAX_JOBS];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        if (r_win.found) begin
                            if (r_busy != 16'hFFFF) begin
                                r_busy <= r_busy + 16'd1;
                            end
                            if (w_fin && (r_fin != 7'(CNT_SAT))) begin
                                r_fin <= r_fin + 7'd1;
                            end
                            if (w_late && (r_late != 7'(CNT_SAT))) begin
                                r_late <= r_late + 7'd1;
                            end
                        end
                        if (r_tick != 16'hFFFF) begin
                            r_tick <= r_tick + 16'd1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/edfrms_cell.sv
// ----------------------------------------------------------------------------
// edfrms_cell
// one job slot: holds the job and folds it into the passing candidate
// ----------------------------------------------------------------------------
module edfrms_cell
    import edfrms_pkg::*;
#(
    parameter int SLOT  = 0,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  t_in              i_wr_data,
    input  logic [CNT_W-1:0] i_cnt,
    input  t_cand            i_cand,
    output t_cand            o_cand
);

    logic [3:0]  r_task;
    logic [15:0] r_rel;
    logic [15:0] r_dl;
    logic [15:0] r_per;
    logic [15:0] r_rem;
    t_cand       r_cand;
    t_cand       n_cand;
    logic        w_hit;
    logic        w_elig;
    logic        w_beats;

    assign w_hit  = (i_ctl.slot == 8'(SLOT));
    assign w_elig = (CNT_W'(SLOT) < i_cnt) && (r_rel <= i_ctl.tick) && (r_rem != 16'd0);

    always_comb begin
        if (i_ctl.use_edf) begin
            w_beats = (r_dl < i_cand.deadline) ||
                      ((r_dl == i_cand.deadline) && (r_rel < i_cand.release_t));
        end else begin
            w_beats = (r_per < i_cand.period) ||
                      ((r_per == i_cand.period) && (r_dl < i_cand.deadline));
        end
        n_cand = i_cand;
        if (w_elig && (!i_cand.found || w_beats)) begin
            n_cand.found     = 1'b1;
            n_cand.slot      = 8'(SLOT);
            n_cand.task_id   = r_task;
            n_cand.release_t = r_rel;
            n_cand.deadline  = r_dl;
            n_cand.period    = r_per;
            n_cand.remaining = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand.vld <= 1'b0;
        end else begin
            r_cand.vld <= n_cand.vld;
        end
        r_cand.found     <= n_cand.found;
        r_cand.slot      <= n_cand.slot;
        r_cand.task_id   <= n_cand.task_id;
        r_cand.release_t <= n_cand.release_t;
        r_cand.deadline  <= n_cand.deadline;
        r_cand.period    <= n_cand.period;
        r_cand.remaining <= n_cand.remaining;
        if (i_ctl.wr_en && w_hit) begin
            r_task <= i_wr_data.task_id;
            r_rel  <= i_wr_data.release_req;
            r_dl   <= i_wr_data.deadline;
            r_per  <= i_wr_data.period;
            r_rem  <= i_wr_data.execution;
        end else if (i_ctl.dec_en && w_hit) begin
            r_rem <= r_rem - 16'd1;
        end
    end

    assign o_cand = r_cand;

endmodule

// File: rtl/edfrms_checker.sv
// ----------------------------------------------------------------------------
// edfrms_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module edfrms_checker
    import edfrms_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall && (i_in_data.func == FUNC_TICK), o_in_stall)
    `ASSERT_IMPL(a_late_fin, i_clk, i_rst_n, o_out_valid && o_out_data.finished_late,
        o_out_data.job_finished)
    `ASSERT_IMPL(a_idle_clean, i_clk, i_rst_n, o_out_valid && o_out_data.idle,
        !o_out_data.job_finished && (o_out_data.run_slot == 6'd0))

endmodule

bind edf_rms_job_scheduler_top edfrms_checker u_edfrms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the edf / rms job scheduler: a directed table of
// adds, ticks and reports followed by random job sets, each result compared
// against an in-bench scheduler model under several idle and stall phases
// ----------------------------------------------------------------------------
module testbench;
    import edfrms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 64;
    localparam int LIMIT = 3_000_000;

    typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b1;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;

    edf_rms_job_scheduler_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // scheduler state
    logic [15:0] job_rel [NSLOT];
    logic [15:0] job_dl [NSLOT];
    logic [15:0] job_rem [NSLOT];
    logic [15:0] job_per [NSLOT];
    logic [3:0]  job_task [NSLOT];
    logic [15:0] now_tick;
    int          n_loaded, n_busy, n_done, n_late;
    logic        edf_mode;

    t_out   sched_expected [$];
    int     errors = 0;
    int     cycle = 0;
    t_phase phase = PH_NONE;
    bit     hold_off = 1'b0;

    task automatic report_mismatch(input string what, input t_out got, input t_out want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    function automatic bit outranks(int a, int b);
        if (edf_mode) begin
            if (job_dl[a] != job_dl[b]) return job_dl[a] < job_dl[b];
            return job_rel[a] < job_rel[b];
        end
        if (job_per[a] != job_per[b]) return job_per[a] < job_per[b];
        return job_dl[a] < job_dl[b];
    endfunction

    function automatic t_out schedule_step(t_in it);
        t_out r;
        int   best;
        int   miss;
        r = '0;
        best = -1;
        if (it.func == FUNC_ADD) begin
            if (n_loaded < NSLOT && it.execution != 0) begin
                job_task[n_loaded] = it.task_id;
                job_rel[n_loaded] = it.release_req;
                job_rem[n_loaded] = it.execution;
                job_dl[n_loaded] = it.deadline;
                job_per[n_loaded] = it.period;
                n_loaded++;
                r.accepted = 1'b1;
            end
        end else if (it.func == FUNC_TICK) begin
            for (int i = 0; i < n_loaded; i++)
                if (job_rel[i] <= now_tick && job_rem[i] != 0)
                    if (best < 0 || outranks(i, best)) best = i;
            if (best < 0) begin
                r.idle = 1'b1;
            end else begin
                r.run_task = job_task[best];
                r.run_slot = best[5:0];
                job_rem[best]--;
                if (n_busy < 65535) n_busy++;
                if (job_rem[best] == 0) begin
                    r.job_finished = 1'b1;
                    if (n_done < CNT_SAT) n_done++;
                    if (int'(now_tick) + 1 > int'(job_dl[best])) begin
                        r.finished_late = 1'b1;
                        if (n_late < CNT_SAT) n_late++;
                    end
                end
            end
            if (now_tick != 16'hFFFF) now_tick++;
        end else if (it.func == FUNC_REPORT) begin
            miss = n_late + (n_loaded > n_done ? n_loaded - n_done : 0);
            r.executed_ticks = n_busy[15:0];
            r.completed_jobs = n_done[6:0];
            r.missed_jobs = (miss > CNT_SAT) ? 7'(CNT_SAT) : miss[6:0];
            r.job_total = n_loaded[6:0];
        end
        return r;
    endfunction

    // checking
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sched_expected.size() == 0) begin
                report_mismatch("unexpected transaction", o_out_data, '0);
            end else begin
                t_out e;
                e = sched_expected.pop_front();
                if (o_out_data !== e)
                    report_mismatch("result", o_out_data, e);
            end
        end
        if (cycle > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_off)
            i_out_stall <= 1'b1;
        else if (phase == PH_RECV)
            i_out_stall <= ($urandom_range(99) < 76);
        else if (phase == PH_BOTH)
            i_out_stall <= ($urandom_range(99) < 15);
        else
            i_out_stall <= 1'b0;
    end

    task automatic long_hold();
        int n;
        n = 0;
        hold_off = 1'b1;
        while (n < 400) begin
            @(posedge i_clk);
            n++;
        end
        hold_off = 1'b0;
    endtask

    task automatic send_item(t_in it, bit check_typed, t_out typed);
        t_out p;
        int   gap;
        gap = 0;
        if (phase == PH_SEND) gap = ($urandom_range(99) < 76) ? $urandom_range(1, 6) : 0;
        if (phase == PH_BOTH) gap = ($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        p = schedule_step(it);
        if (check_typed && p !== typed) report_mismatch("directed row", p, typed);
        sched_expected.push_back(p);
        i_in_data <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sched_expected.size() != 0) @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
    endtask

    task automatic set_mode(bit edf);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= edf;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        edf_mode = edf;
    endtask

    function automatic t_in mk(logic [1:0] f, logic [3:0] t, logic [15:0] r,
                               logic [15:0] e, logic [15:0] d, logic [15:0] p);
        t_in it;
        it.func = f; it.task_id = t; it.release_req = r;
        it.execution = e; it.deadline = d; it.period = p;
        return it;
    endfunction

    function automatic t_in rand_add(bit wide);
        t_in it;
        int  rl;
        rl = wide ? $urandom_range(65535) : int'(now_tick) + $urandom_range(0, 30);
        it.func = FUNC_ADD;
        it.task_id = 4'($urandom_range(15));
        it.release_req = wide ? rl[15:0] : ((rl > 65535) ? 16'hFFFF : rl[15:0]);
        it.execution = ($urandom_range(19) == 0) ? 16'($urandom) :
                                                  16'($urandom_range(1, 6));
        if ($urandom_range(29) == 0) it.execution = 16'd0;
        it.deadline = wide ? 16'($urandom) : 16'(int'(it.release_req) + $urandom_range(0, 40));
        it.period = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        return it;
    endfunction

    typedef struct {
        t_in  it;
        bit   typed;
        t_out want;
    } t_row;

    initial begin
        t_row rows [$];
        t_out w;
        int   sent;
        int   k;

        edf_mode = 1'b1;
        now_tick = '0;
        n_loaded = 0; n_busy = 0; n_done = 0; n_late = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        w = '0; w.idle = 1'b1;
        rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0), 1, w});
        w = '0;
        rows.push_back('{mk(FUNC_REPORT, 0, 0, 0, 0, 0), 1, w});
        rows.push_back('{mk(FUNC_ADD, 15, 0, 0, 5, 3), 1, w});
        rows.push_back('{mk(2'd3, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1, w});
        w.accepted = 1'b1;
        rows.push_back('{mk(FUNC_ADD, 15, 0, 2, 9, 16'hFFFF), 1, w});
        rows.push_back('{mk(FUNC_ADD, 1, 0, 1, 3, 0), 1, w});
        rows.push_back('{mk(FUNC_ADD, 2, 0, 1, 3, 4), 1, w});
        rows.push_back('{mk(FUNC_ADD, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1), 1, w});
        rows.push_back('{mk(FUNC_ADD, 4, 1, 3, 0, 5), 1, w});
        for (int i = 0; i < 6; i++)
            rows.push_back('{mk(FUNC_TICK, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(FUNC_REPORT, 0, 0, 0, 0, 0), 0, '0});
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

        set_mode(1'b0);
        for (int i = 0; i < 3; i++) send_item(mk(FUNC_ADD, 5, 0, 2, 20, 2), 0, '0);
        for (int i = 0; i < 6; i++) send_item(mk(FUNC_TICK, 0, 0, 0, 0, 0), 0, '0);
        send_item(mk(FUNC_REPORT, 0, 0, 0, 0, 0), 0, '0);

        // random part; each job set is a random mix of adds, ticks and reports
        sent = 0;
        k = 0;
        while (sent < 1300) begin
            phase = t_phase'(k % 4);
            if (k == 1) fork long_hold(); join_none
            for (int n = 0; n < 110; n++) begin
                t_in it;
                int  r;
                r = $urandom_range(99);
                if (r < 35) it = rand_add(k % 5 == 4);
                else if (r < 88) it = mk(FUNC_TICK, 4'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom), 16'($urandom));
                else if (r < 97) it = mk(FUNC_REPORT, 4'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom), 16'($urandom));
                else it = mk(2'd3, 4'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
                send_item(it, 0, '0);
                sent++;
            end
            if (k == 2) begin
                // table full of jobs then adds beyond it
                for (int n = 0; n < 70; n++) begin
                    send_item(mk(FUNC_ADD, 4'(n), 0, 1, 16'(n), 16'(n)), 0, '0);
                    sent++;
                end
            end
            if (k == 3) begin
                // a run of ticks from an empty pipeline
                drain();
                for (int n = 0; n < 40; n++) begin
                    send_item(mk(FUNC_TICK, 0, 0, 0, 0, 0), 0, '0);
                    sent++;
                end
            end
            set_mode(k % 2);
            k++;
        end

        phase = PH_NONE;
        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
